/* rtl/core/lbr_pkg.sv */
// Shared types, constants and helper functions of the longest bit run tracker.
package lbr_pkg;

  localparam int LBR_WORD_BITS = 32;
  localparam int LEN_W         = 6;
  localparam int IN_W          = 32;

  localparam logic [IN_W-1:0] ALT_PAT_A = 32'h5555_5555;
  localparam logic [IN_W-1:0] ALT_PAT_B = 32'hAAAA_AAAA;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } lbr_state_t;

  // Status from the run-length unit to the sequencer
  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] one_len;
    logic [LEN_W-1:0] zero_len;
    logic [LEN_W-1:0] alt_a_len;
    logic [LEN_W-1:0] alt_b_len;
  } run_stat_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } dec_pair_t;

  // Seven-segment code, segment a in bit 0 through g in bit 6
  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] code;
    case (d)
      4'd0:    code = 8'b0011_1111;
      4'd1:    code = 8'b0000_0110;
      4'd2:    code = 8'b0101_1011;
      4'd3:    code = 8'b0100_1111;
      4'd4:    code = 8'b0110_0110;
      4'd5:    code = 8'b0110_1101;
      4'd6:    code = 8'b0111_1101;
      4'd7:    code = 8'b0000_0111;
      4'd8:    code = 8'b0111_1111;
      4'd9:    code = 8'b0110_0111;
      default: code = 8'b0000_0000;
    endcase
    return code;
  endfunction

  // Split a 6-bit value into decimal tens and units by compare and subtract
  function automatic dec_pair_t dec_split(input logic [LEN_W-1:0] v);
    dec_pair_t  r;
    logic [3:0] t;
    logic [LEN_W-1:0] tens10;
    if (v >= LEN_W'(60))      t = 4'd6;
    else if (v >= LEN_W'(50)) t = 4'd5;
    else if (v >= LEN_W'(40)) t = 4'd4;
    else if (v >= LEN_W'(30)) t = 4'd3;
    else if (v >= LEN_W'(20)) t = 4'd2;
    else if (v >= LEN_W'(10)) t = 4'd1;
    else                      t = 4'd0;
    tens10  = LEN_W'({t, 3'b000}) + LEN_W'({t, 1'b0});
    r.tens  = t;
    r.units = 4'(v - tens10);
    return r;
  endfunction

endpackage

/* rtl/core/lbr_ifs.sv */
// Handshake channel interfaces for the input word and the result.
interface lbr_word_if;
  import lbr_pkg::*;
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface lbr_result_if;
  import lbr_pkg::*;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] max_zero_run;
  logic [LEN_W-1:0] max_one_run;
  logic [LEN_W-1:0] max_alt_run;
  logic [31:0]      seg_four_digits;
  logic [15:0]      seg_two_digits;
  logic             batch_end;

  modport source (output valid, output max_zero_run, output max_one_run,
                  output max_alt_run, output seg_four_digits, output seg_two_digits,
                  output batch_end, input ready);
  modport sink   (input valid, input max_zero_run, input max_one_run,
                  input max_alt_run, input seg_four_digits, input seg_two_digits,
                  input batch_end, output ready);
endinterface

/* rtl/core/lbr_run_unit.sv */
// Iterative shift-and-AND unit measuring four run lengths of one word.
module lbr_run_unit #(
  parameter int WORD_BITS = lbr_pkg::LBR_WORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [WORD_BITS-1:0]  word,
  output lbr_pkg::run_stat_t    stat
);
  import lbr_pkg::*;

  localparam int LANES = 4;

  logic [WORD_BITS-1:0] lane [LANES];
  logic [LEN_W-1:0]     len  [LANES];
  logic                 busy;
  logic                 done;
  logic                 all_zero;

  // Loop ends once every lane has collapsed to zero
  always_comb begin
    all_zero = (lane[0] == '0) && (lane[1] == '0) && (lane[2] == '0) && (lane[3] == '0);
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && all_zero) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Load the lanes, then shift-and-AND each one and count the steps it survives
  always_ff @(posedge clk) begin
    if (start) begin
      lane[0] <= word;
      lane[1] <= ~word;
      lane[2] <= word ^ ALT_PAT_A[WORD_BITS-1:0];
      lane[3] <= word ^ ALT_PAT_B[WORD_BITS-1:0];
      for (int i = 0; i < LANES; i++) len[i] <= '0;
    end else if (busy && !all_zero) begin
      for (int i = 0; i < LANES; i++) begin
        lane[i] <= lane[i] & (lane[i] >> 1);
        if (lane[i] != '0) len[i] <= len[i] + LEN_W'(1);
      end
    end
  end

  assign stat.done      = done;
  assign stat.one_len   = len[0];
  assign stat.zero_len  = len[1];
  assign stat.alt_a_len = len[2];
  assign stat.alt_b_len = len[3];

endmodule

/* rtl/core/lbr_seg_enc.sv */
// Decimal split and seven-segment encoding of the three maxima.
module lbr_seg_enc (
  input  logic [lbr_pkg::LEN_W-1:0] zero_run,
  input  logic [lbr_pkg::LEN_W-1:0] one_run,
  input  logic [lbr_pkg::LEN_W-1:0] alt_run,
  output logic [31:0]               seg4,
  output logic [15:0]               seg2
);
  import lbr_pkg::*;

  dec_pair_t zero_dec;
  dec_pair_t one_dec;
  dec_pair_t alt_dec;

  // zeros*100+ones: zeros supply thousands and hundreds, ones tens and units
  always_comb begin
    zero_dec = dec_split(zero_run);
    one_dec  = dec_split(one_run);
    alt_dec  = dec_split(alt_run);
    seg4 = {seg_code(zero_dec.tens), seg_code(zero_dec.units),
            seg_code(one_dec.tens), seg_code(one_dec.units)};
    seg2 = {seg_code(alt_dec.tens), seg_code(alt_dec.units)};
  end

endmodule

/* rtl/core/longest_bit_run_tracker.sv */
// Longest bit run tracker: top level with sequencer, batch maxima and result register.
//
// Each input word has its runs of ones, zeros and alternating patterns measured in the
// run unit, which makes one shift-and-AND step per cycle until every lane is zero;
// a zero (terminator) word skips the run unit and goes straight to the emit step.
// A word whose result finds the previous one still waiting for its transfer stays in
// the emit step until that transfer completes. One word is in work at a time and the
// input is not ready meanwhile; a finished result waits in the output register while
// the next word is taken. Only the low WORD_BITS bits of a word are looked at.
// A terminator reports the batch maxima with batch_end set and clears them; a
// terminator first in a batch reports zeros.
module longest_bit_run_tracker #(
  parameter int WORD_BITS = lbr_pkg::LBR_WORD_BITS
) (
  input logic         clk,
  input logic         rst,
  lbr_word_if.sink    item,
  lbr_result_if.source result
);
  import lbr_pkg::*;

  lbr_state_t        state, state_next;
  run_stat_t         run_stat;
  logic              run_start;
  logic              out_load;
  logic              accept;
  logic              word_zero;
  logic              end_flag;
  logic [LEN_W-1:0]  best_zero_run, best_one_run, best_alt_run;
  logic [LEN_W-1:0]  alt_len;
  logic [31:0]       seg4;
  logic [15:0]       seg2;
  logic              out_valid;
  logic [LEN_W-1:0]  out_zero, out_one, out_alt;
  logic [31:0]       out_seg4;
  logic [15:0]       out_seg2;
  logic              out_end;

  assign word_zero  = (item.word[WORD_BITS-1:0] == '0);
  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;

  lbr_run_unit #(.WORD_BITS(WORD_BITS)) u_run (
    .clk   (clk),
    .rst   (rst),
    .start (run_start),
    .word  (item.word[WORD_BITS-1:0]),
    .stat  (run_stat)
  );

  lbr_seg_enc u_seg (
    .zero_run (best_zero_run),
    .one_run  (best_one_run),
    .alt_run  (best_alt_run),
    .seg4     (seg4),
    .seg2     (seg2)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencer outputs
  always_comb begin
    state_next = state;
    run_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (item.valid) begin
          if (word_zero) begin
            state_next = ST_EMIT;
          end else begin
            run_start  = 1'b1;
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (run_stat.done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Remember whether the word in work is the terminator
  always_ff @(posedge clk) begin
    if (rst) begin
      end_flag <= 1'b0;
    end else if (accept) begin
      end_flag <= word_zero;
    end
  end

  assign alt_len = (run_stat.alt_a_len > run_stat.alt_b_len) ?
                   run_stat.alt_a_len : run_stat.alt_b_len;

  // Advance the batch maxima; drop them once a terminator result is out
  always_ff @(posedge clk) begin
    if (rst) begin
      best_zero_run <= '0;
      best_one_run  <= '0;
      best_alt_run  <= '0;
    end else if (run_stat.done) begin
      if (run_stat.zero_len > best_zero_run) best_zero_run <= run_stat.zero_len;
      if (run_stat.one_len > best_one_run)   best_one_run  <= run_stat.one_len;
      if (alt_len > best_alt_run)            best_alt_run  <= alt_len;
    end else if (out_load && end_flag) begin
      best_zero_run <= '0;
      best_one_run  <= '0;
      best_alt_run  <= '0;
    end
  end

  // Output register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_zero <= best_zero_run;
      out_one  <= best_one_run;
      out_alt  <= best_alt_run;
      out_seg4 <= seg4;
      out_seg2 <= seg2;
      out_end  <= end_flag;
    end
  end

  assign result.valid           = out_valid;
  assign result.max_zero_run    = out_zero;
  assign result.max_one_run     = out_one;
  assign result.max_alt_run     = out_alt;
  assign result.seg_four_digits = out_seg4;
  assign result.seg_two_digits  = out_seg2;
  assign result.batch_end       = out_end;

  // A terminator result leaves the maxima cleared
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    out_load && end_flag |=>
      best_zero_run == '0 && best_one_run == '0 && best_alt_run == '0)
    else $error("maxima not cleared after batch end");

  // The run unit finishes only while the sequencer waits for it
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    run_stat.done |-> state == ST_RUN)
    else $error("run unit done outside run state");

  // Maxima never fall while a word is folded in
  a_max_monotonic: assert property (@(posedge clk) disable iff (rst)
    run_stat.done |=> best_one_run >= $past(best_one_run) &&
                      best_zero_run >= $past(best_zero_run) &&
                      best_alt_run >= $past(best_alt_run))
    else $error("batch maximum decreased");

  // No run can exceed the word width
  a_max_bound: assert property (@(posedge clk) disable iff (rst)
    best_one_run <= LEN_W'(WORD_BITS) && best_zero_run <= LEN_W'(WORD_BITS) &&
    best_alt_run <= LEN_W'(WORD_BITS))
    else $error("run maximum beyond word width");

endmodule

/* dv/longest_bit_run_tracker_test.sv */
// Self-checking testbench of the longest bit run tracker: random words, batches and stalls.
module longest_bit_run_tracker_test;
  import lbr_pkg::*;

  // Digit glyphs, segment a in bit 0 through g in bit 6
  localparam logic [7:0] DIGIT_GLYPH [10] = '{
    8'b0011_1111, 8'b0000_0110, 8'b0101_1011, 8'b0100_1111, 8'b0110_0110,
    8'b0110_1101, 8'b0111_1101, 8'b0000_0111, 8'b0111_1111, 8'b0110_0111
  };
  localparam int unsigned SETTLE_CYCLES = 100;

  typedef struct packed {
    logic [LEN_W-1:0] zero_run;
    logic [LEN_W-1:0] one_run;
    logic [LEN_W-1:0] alt_run;
    logic [31:0]      seg4;
    logic [15:0]      seg2;
    logic             batch_end;
  } run_report_t;

  typedef struct {
    logic [IN_W-1:0] word;
    int unsigned     gap;
    bit              drain;
  } word_slot_t;

  logic clk;
  logic rst;

  lbr_word_if   item_ch ();
  lbr_result_if result_ch ();

  longest_bit_run_tracker DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  word_slot_t  word_queue [$];
  run_report_t report_queue [$];

  logic [LEN_W-1:0] batch_zero_best;
  logic [LEN_W-1:0] batch_one_best;
  logic [LEN_W-1:0] batch_alt_best;

  int unsigned mismatches;
  int unsigned reports_checked;
  int unsigned words_sent;
  int unsigned batches_closed;
  int unsigned gap_left;
  int          in_flight;
  int unsigned stall_left;
  int unsigned cycle_count;

  always #5 clk = ~clk;

  // Longest run of set bits, found by a plain scan
  function automatic int unsigned longest_set_run(logic [31:0] v);
    int unsigned run;
    int unsigned best;
    run  = 0;
    best = 0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        run++;
        if (run > best) best = run;
      end else begin
        run = 0;
      end
    end
    return best;
  endfunction

  function automatic logic [7:0] glyph(int unsigned v);
    return DIGIT_GLYPH[v % 10];
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Nonzero word with a shape chosen at random
  function automatic logic [31:0] shaped_word();
    logic [31:0] w;
    int unsigned len;
    int unsigned pos;
    len = $urandom_range(1, 32);
    pos = $urandom_range(0, 32 - len);
    case ($urandom_range(0, 5))
      0: w = $urandom;
      1: w = 32'(((64'd1 << len) - 64'd1) << pos);
      2: w = ~32'(((64'd1 << len) - 64'd1) << pos);
      3: begin
        w = $urandom_range(0, 1) ? ALT_PAT_A : ALT_PAT_B;
        repeat ($urandom_range(0, 2)) w[$urandom_range(0, 31)] ^= 1'b1;
      end
      4: w = $urandom & $urandom & $urandom;
      default: w = $urandom | $urandom | $urandom;
    endcase
    if (w == '0) w = $urandom | 32'h1;
    return w;
  endfunction

  // Fold one word into the batch maxima and form the result it reports
  task automatic tally_word(input logic [31:0] w, output run_report_t r);
    int unsigned pair;
    if (w != '0) begin
      if (longest_set_run(~w) > batch_zero_best) batch_zero_best = LEN_W'(longest_set_run(~w));
      if (longest_set_run(w) > batch_one_best) batch_one_best = LEN_W'(longest_set_run(w));
      if (longest_set_run(w ^ ALT_PAT_A) > batch_alt_best)
        batch_alt_best = LEN_W'(longest_set_run(w ^ ALT_PAT_A));
      if (longest_set_run(w ^ ALT_PAT_B) > batch_alt_best)
        batch_alt_best = LEN_W'(longest_set_run(w ^ ALT_PAT_B));
    end
    pair        = batch_zero_best * 100 + batch_one_best;
    r.zero_run  = batch_zero_best;
    r.one_run   = batch_one_best;
    r.alt_run   = batch_alt_best;
    r.seg4      = {glyph(pair / 1000), glyph(pair / 100), glyph(pair / 10), glyph(pair)};
    r.seg2      = {glyph(batch_alt_best / 10), glyph(batch_alt_best)};
    r.batch_end = (w == '0);
    if (w == '0) begin
      batch_zero_best = '0;
      batch_one_best  = '0;
      batch_alt_best  = '0;
    end
  endtask

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t: mismatch on %s: got 'h%0h, expected 'h%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic queue_word(logic [31:0] w, int unsigned gap, bit drain);
    word_slot_t s;
    s.word  = w;
    s.gap   = gap;
    s.drain = drain;
    word_queue.push_back(s);
  endtask

  // Word driver: hold a presented word until its transfer, then wait out the next gap
  always @(posedge clk) begin
    logic            drive_valid;
    logic [IN_W-1:0] drive_word;
    if (rst) begin
      item_ch.valid <= 1'b0;
      item_ch.word  <= '0;
      gap_left  = 0;
      in_flight = 0;
    end else begin
      drive_valid = 1'b0;
      drive_word  = $urandom;
      if (result_ch.valid && result_ch.ready) in_flight--;
      if (item_ch.valid && item_ch.ready) begin
        in_flight++;
        void'(word_queue.pop_front());
        if (word_queue.size() > 0) gap_left = word_queue[0].gap;
      end
      if (item_ch.valid && !item_ch.ready) begin
        drive_valid = 1'b1;
        drive_word  = item_ch.word;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (word_queue.size() > 0 && !(word_queue[0].drain && in_flight != 0)) begin
        drive_valid = 1'b1;
        drive_word  = word_queue[0].word;
      end
      item_ch.valid <= drive_valid;
      item_ch.word  <= drive_word;
    end
  end

  // Result stall: stretches of free flow alternate with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left  = 0;
      cycle_count = 0;
    end else begin
      cycle_count++;
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        if (cycle_count[10] && $urandom_range(0, 2) == 0) stall_left = idle_length();
      end
    end
  end

  // Monitor: check each result transfer, then predict on each word transfer
  always @(posedge clk) begin
    run_report_t want;
    run_report_t fresh;
    if (rst) begin
      batch_zero_best = '0;
      batch_one_best  = '0;
      batch_alt_best  = '0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (report_queue.size() == 0) begin
          $display("%0t: result with no word waiting for it", $realtime);
          mismatches++;
        end else begin
          want = report_queue.pop_front();
          reports_checked++;
          if (result_ch.max_zero_run !== want.zero_run)
            flag_mismatch("max_zero_run", result_ch.max_zero_run, want.zero_run);
          if (result_ch.max_one_run !== want.one_run)
            flag_mismatch("max_one_run", result_ch.max_one_run, want.one_run);
          if (result_ch.max_alt_run !== want.alt_run)
            flag_mismatch("max_alt_run", result_ch.max_alt_run, want.alt_run);
          if (result_ch.seg_four_digits !== want.seg4)
            flag_mismatch("seg_four_digits", result_ch.seg_four_digits, want.seg4);
          if (result_ch.seg_two_digits !== want.seg2)
            flag_mismatch("seg_two_digits", result_ch.seg_two_digits, want.seg2);
          if (result_ch.batch_end !== want.batch_end)
            flag_mismatch("batch_end", result_ch.batch_end, want.batch_end);
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        tally_word(item_ch.word, fresh);
        report_queue.push_back(fresh);
        words_sent++;
        if (fresh.batch_end) batches_closed++;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned batch_len;
    bit          calm;
    clk = 1'b0;
    rst = 1'b1;
    mismatches      = 0;
    reports_checked = 0;
    words_sent      = 0;
    batches_closed  = 0;

    // Directed: empty batch first, field extremes, both alternating phases, top digit
    queue_word(32'h0000_0000, 0, 0);
    queue_word(32'hFFFF_FFFF, 0, 0);
    queue_word(32'h0000_0000, 0, 0);
    queue_word(32'h0000_0001, 2, 0);
    queue_word(32'hFFFF_FFFF, 0, 0);
    queue_word(32'h0000_0000, 0, 0);
    queue_word(32'h0000_0000, 0, 0);
    queue_word(32'h8000_0000, 0, 0);
    queue_word(32'h5555_5555, 1, 0);
    queue_word(32'h0000_0000, 0, 0);
    queue_word(32'hAAAA_AAAA, 0, 0);
    queue_word(32'h7FFF_FFFE, 0, 0);
    queue_word(32'h0000_0000, 3, 0);
    queue_word(32'h0000_FFFF, 0, 0);
    queue_word(32'hFFFF_0000, 0, 0);
    queue_word(32'h0000_0000, 0, 0);
    queue_word(32'h1234_5678, 0, 1);
    queue_word(32'hF0F0_F0F0, 0, 0);
    queue_word(32'h5555_5554, 0, 0);
    queue_word(32'hD555_5555, 0, 0);
    queue_word(32'h0000_0000, 0, 0);

    // Random: batches of shaped words closed by a terminator, some left open
    while (word_queue.size() < 520) begin
      calm      = ($urandom_range(0, 4) == 0);
      batch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 6);
      repeat (batch_len)
        queue_word(shaped_word(), calm ? 0 : idle_length(), $urandom_range(0, 99) == 0);
      if ($urandom_range(0, 9) != 0) queue_word('0, calm ? 0 : idle_length(), 0);
    end
    queue_word('0, 0, 1);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Drain: every word taken and every result seen, then let the block settle
    do @(negedge clk);
    while (word_queue.size() > 0 || report_queue.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (report_queue.size() > 0) begin
      $display("%0d results never arrived", report_queue.size());
      mismatches++;
    end

    $display("Ran %0d words over %0d closed batches, %0d results checked field by field",
             words_sent, batches_closed, reports_checked);
    $display("with random gaps on the word side and random stalls on the result side");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timeout with %0d words and %0d results outstanding",
             word_queue.size(), report_queue.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
